// ----- src/rate_bounded_torque_stepper_defines.svh -----
// Assertion macros for the torque stepper.
// Used by rate_bounded_torque_stepper; no other dependencies.
`ifndef RATE_BOUNDED_TORQUE_STEPPER_DEFINES_SVH
`define RATE_BOUNDED_TORQUE_STEPPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RBTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbts: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbts: next-cycle check failed");

`endif

// ----- src/rbts_pkg.sv -----
// Shared types and constants for the rate bounded torque stepper.
// No dependencies.
package rbts_pkg;

    localparam int TORQUE_W   = 17;
    localparam int CMD_W      = 9;
    localparam int RATE_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LIM_W      = 15;
    localparam int TLIM_W     = 8;
    localparam int STEP_W     = 16;

    localparam logic [15:0] FINE_MAX = 16'hFFFF;
    localparam logic [8:0]  CMD_POS_MAX = 9'd255;
    localparam logic [8:0]  CMD_NEG_MAX = 9'd256;

    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_LIMIT     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TORQUE_LIMIT    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_TOLERANCE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FULL_RATE_RES   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RATE        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_RATE        = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_TORQUE_STEP     = 3'd6;

    localparam logic [LIM_W-1:0]  RST_ANGLE_LIMIT     = 15'd4500;
    localparam logic [TLIM_W-1:0] RST_TORQUE_LIMIT    = 8'd64;
    localparam logic [LIM_W-1:0]  RST_ANGLE_TOLERANCE = 15'd10;
    localparam logic [LIM_W-1:0]  RST_FULL_RATE_RES   = 15'd100;
    localparam logic [LIM_W-1:0]  RST_MIN_RATE        = 15'd50;
    localparam logic [LIM_W-1:0]  RST_MAX_RATE        = 15'd2000;
    localparam logic [STEP_W-1:0] RST_TORQUE_STEP     = 16'd64;

    typedef enum logic [2:0] {
        ACT_HELD        = 3'd0,
        ACT_DOWN        = 3'd1,
        ACT_UP          = 3'd2,
        ACT_ANGLE_CUT   = 3'd3,
        ACT_TORQUE_CUT  = 3'd4,
        ACT_SENSOR_LOST = 3'd5,
        ACT_NO_TARGET   = 3'd6
    } action_t;

endpackage

// ----- src/rbts_if.sv -----
// Request channels of the torque stepper: sample in, result out, config write.
// Depends on rbts_pkg.
interface rbts_sample_if #(parameter int ANGLE_BITS = 16);
    logic                                 valid;
    logic                                 ready;
    logic                                 sensor_valid;
    logic                                 target_valid;
    logic signed [ANGLE_BITS-1:0]         target_angle;
    logic signed [ANGLE_BITS-1:0]         measured_angle;
    logic signed [rbts_pkg::RATE_W-1:0]   angular_rate;

    modport source (output valid, sensor_valid, target_valid, target_angle,
                    measured_angle, angular_rate, input ready);
    modport sink   (input valid, sensor_valid, target_valid, target_angle,
                    measured_angle, angular_rate, output ready);
endinterface

interface rbts_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rbts_pkg::TORQUE_W-1:0] torque_fine;
    logic signed [rbts_pkg::CMD_W-1:0]    torque_command;
    rbts_pkg::action_t                    action;

    modport source (output valid, torque_fine, torque_command, action, input ready);
    modport sink   (input valid, torque_fine, torque_command, action, output ready);
endinterface

interface rbts_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [rbts_pkg::CFG_ADDR_W-1:0]      addr;
    logic [rbts_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/rate_bounded_torque_stepper.sv -----
// Rate bounded steering torque stepper: top level. Depends on rbts_pkg, rbts_if and
// rate_bounded_torque_stepper_defines.svh. Each accepted sample request updates the
// fine torque accumulator and, unless it is the first valid sample after reset or a
// sensor loss, loads one result into the output register at the same edge. One sample
// is taken per clock while the output register is empty or its result is being taken;
// the accumulator's next value feeds the next sample. The output register decouples
// the sides: a new sample is taken while the result is being taken in the same cycle.
// Config writes are always ready and take effect on the next cycle.
`include "rate_bounded_torque_stepper_defines.svh"

module rate_bounded_torque_stepper #(
    parameter int ANGLE_BITS       = 16,
    parameter int TORQUE_FRAC_BITS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rbts_cfg_if.sink              cfg,
    rbts_sample_if.sink           sample,
    rbts_result_if.source         result
);

    localparam int TW  = rbts_pkg::TORQUE_W;
    localparam int VW  = rbts_pkg::RATE_W + 1;
    localparam int BW  = (ANGLE_BITS > rbts_pkg::LIM_W) ? ANGLE_BITS : rbts_pkg::LIM_W;
    localparam int RTW = BW + 2;
    localparam int DW  = rbts_pkg::LIM_W + 1;
    localparam int PW0 = VW + DW;
    localparam int PW1 = DW + RTW;
    localparam int PW  = ((PW0 > PW1) ? PW0 : PW1) + 1;
    localparam int CW0 = rbts_pkg::TLIM_W + 1 + TORQUE_FRAC_BITS;
    localparam int CW  = (CW0 > TW) ? CW0 : TW;
    localparam int LW0 = rbts_pkg::TLIM_W + TORQUE_FRAC_BITS;
    localparam int LW  = (LW0 > 16) ? LW0 : 16;
    localparam int SW  = TW + 2;

    // configuration registers
    logic [rbts_pkg::LIM_W-1:0]  angle_limit_reg;
    logic [rbts_pkg::TLIM_W-1:0] torque_limit_reg;
    logic [rbts_pkg::LIM_W-1:0]  angle_tolerance_reg;
    logic [rbts_pkg::LIM_W-1:0]  full_rate_res_reg;
    logic [rbts_pkg::LIM_W-1:0]  min_rate_reg;
    logic [rbts_pkg::LIM_W-1:0]  max_rate_reg;
    logic [rbts_pkg::STEP_W-1:0] torque_step_reg;

    // state and output register
    logic signed [TW-1:0]                torque_accum_reg, torque_accum_next;
    logic                                first_sample_reg, first_sample_next;
    logic                                out_valid_reg, out_valid_next;
    logic signed [TW-1:0]                torque_fine_reg;
    logic signed [rbts_pkg::CMD_W-1:0]   torque_command_reg, torque_command_next;
    rbts_pkg::action_t                   action_reg, action_next;

    logic sample_acc;
    logic produce;

    // rate bound, lane 0 direct, lane 1 mirrored
    logic signed [RTW-1:0] lane_r   [2];
    logic signed [VW-1:0]  lane_v   [2];
    logic                  above    [2];
    logic signed [DW:0]    d_raw;
    logic signed [DW-1:0]  d_s;
    logic signed [RTW-1:0] f_s, t_s;
    logic signed [VW-1:0]  m_v, neg_m_v, max_v;
    logic signed [DW-1:0]  m_d;
    logic signed [PW-1:0]  lhs      [2];
    logic signed [PW-1:0]  rhs      [2];

    // limits
    logic [ANGLE_BITS-1:0] meas_abs;
    logic [TW-1:0]         accum_abs;
    logic [CW0-1:0]        cut;
    logic [LW-1:0]         lim_wide;
    logic [15:0]           lim16;
    logic signed [SW-1:0]  res, lim_s, step_s;

    // command
    logic [TW-1:0]         cmd_mag;
    logic [TW-1:0]         cmd_sh;
    logic [8:0]            cmd_sat;

    assign cfg.ready    = 1'b1;
    assign sample.ready = !out_valid_reg || result.ready;
    assign sample_acc   = sample.valid && sample.ready;

    assign result.valid          = out_valid_reg;
    assign result.torque_fine    = torque_fine_reg;
    assign result.torque_command = torque_command_reg;
    assign result.action         = action_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_limit_reg     <= rbts_pkg::RST_ANGLE_LIMIT;
            torque_limit_reg    <= rbts_pkg::RST_TORQUE_LIMIT;
            angle_tolerance_reg <= rbts_pkg::RST_ANGLE_TOLERANCE;
            full_rate_res_reg   <= rbts_pkg::RST_FULL_RATE_RES;
            min_rate_reg        <= rbts_pkg::RST_MIN_RATE;
            max_rate_reg        <= rbts_pkg::RST_MAX_RATE;
            torque_step_reg     <= rbts_pkg::RST_TORQUE_STEP;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                rbts_pkg::CFG_ANGLE_LIMIT:     angle_limit_reg     <= cfg.data[14:0];
                rbts_pkg::CFG_TORQUE_LIMIT:    torque_limit_reg    <= cfg.data[7:0];
                rbts_pkg::CFG_ANGLE_TOLERANCE: angle_tolerance_reg <= cfg.data[14:0];
                rbts_pkg::CFG_FULL_RATE_RES:   full_rate_res_reg   <= cfg.data[14:0];
                rbts_pkg::CFG_MIN_RATE:        min_rate_reg        <= cfg.data[14:0];
                rbts_pkg::CFG_MAX_RATE:        max_rate_reg        <= cfg.data[14:0];
                rbts_pkg::CFG_TORQUE_STEP:     torque_step_reg     <= cfg.data;
                default:                       ;
            endcase
        end
    end

    // bound operands
    always_comb
    begin
        d_raw   = $signed({2'b00, full_rate_res_reg}) - $signed({2'b00, angle_tolerance_reg});
        d_s     = (d_raw <= 0) ? DW'(1) : d_raw[DW-1:0];
        f_s     = $signed(RTW'(full_rate_res_reg));
        t_s     = $signed(RTW'(angle_tolerance_reg));
        m_v     = $signed(VW'(min_rate_reg));
        neg_m_v = -m_v;
        max_v   = $signed(VW'(max_rate_reg));
        m_d     = $signed({1'b0, min_rate_reg});

        lane_r[0] = RTW'(sample.target_angle) - RTW'(sample.measured_angle);
        lane_r[1] = -lane_r[0];
        lane_v[0] = VW'(sample.angular_rate);
        lane_v[1] = -lane_v[0];

        for (int i = 0; i < 2; i++)
        begin
            lhs[i]   = PW'(lane_v[i]) * PW'(d_s);
            rhs[i]   = PW'(m_d) * PW'(lane_r[i] + t_s);
            above[i] = (lane_r[i] <= -f_s) ? (lane_v[i] > neg_m_v)
                                          : ((lane_v[i] > max_v) || (lhs[i] > rhs[i]));
        end
    end

    // limits and step
    always_comb
    begin
        meas_abs  = sample.measured_angle[ANGLE_BITS-1] ? ANGLE_BITS'(-sample.measured_angle)
                                                         : ANGLE_BITS'(sample.measured_angle);
        accum_abs = torque_accum_reg[TW-1] ? TW'(-torque_accum_reg) : TW'(torque_accum_reg);
        cut       = (CW0'(torque_limit_reg) + CW0'(1)) << TORQUE_FRAC_BITS;
        lim_wide  = LW'(torque_limit_reg) << TORQUE_FRAC_BITS;
        lim16     = (lim_wide > LW'(rbts_pkg::FINE_MAX)) ? rbts_pkg::FINE_MAX : lim_wide[15:0];
        lim_s     = $signed(SW'(lim16));
        step_s    = $signed(SW'(torque_step_reg));
        res       = SW'(torque_accum_reg);

        torque_accum_next = torque_accum_reg;
        first_sample_next = first_sample_reg;
        action_next       = rbts_pkg::ACT_HELD;
        produce           = 1'b1;

        if (!sample.sensor_valid)
        begin
            torque_accum_next = '0;
            first_sample_next = 1'b1;
            action_next       = rbts_pkg::ACT_SENSOR_LOST;
        end
        else if (first_sample_reg)
        begin
            first_sample_next = 1'b0;
            produce           = 1'b0;
        end
        else if (!sample.target_valid)
        begin
            action_next = rbts_pkg::ACT_NO_TARGET;
        end
        else if (BW'(meas_abs) > BW'(angle_limit_reg))
        begin
            torque_accum_next = '0;
            action_next       = rbts_pkg::ACT_ANGLE_CUT;
        end
        else if (CW'(accum_abs) > CW'(cut))
        begin
            torque_accum_next = '0;
            action_next       = rbts_pkg::ACT_TORQUE_CUT;
        end
        else
        begin
            if (above[0])
            begin
                res         = res - step_s;
                action_next = rbts_pkg::ACT_DOWN;
            end
            else if (above[1])
            begin
                res         = res + step_s;
                action_next = rbts_pkg::ACT_UP;
            end
            if (res < -lim_s)
            begin
                res = -lim_s;
            end
            if (res > lim_s)
            begin
                res = lim_s;
            end
            torque_accum_next = res[TW-1:0];
        end
    end

    // whole units, truncated toward zero, saturated
    always_comb
    begin
        cmd_mag = torque_accum_next[TW-1] ? TW'(-torque_accum_next) : TW'(torque_accum_next);
        cmd_sh  = cmd_mag >> TORQUE_FRAC_BITS;
        if (torque_accum_next[TW-1])
        begin
            cmd_sat             = (cmd_sh > TW'(rbts_pkg::CMD_NEG_MAX)) ? rbts_pkg::CMD_NEG_MAX
                                                                         : cmd_sh[8:0];
            torque_command_next = $signed(-cmd_sat);
        end
        else
        begin
            cmd_sat             = (cmd_sh > TW'(rbts_pkg::CMD_POS_MAX)) ? rbts_pkg::CMD_POS_MAX
                                                                         : cmd_sh[8:0];
            torque_command_next = $signed(cmd_sat);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (sample_acc && produce)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            torque_accum_reg <= '0;
            first_sample_reg <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (sample_acc)
            begin
                torque_accum_reg <= torque_accum_next;
                first_sample_reg <= first_sample_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc && produce)
        begin
            torque_fine_reg    <= torque_accum_next;
            torque_command_reg <= torque_command_next;
            action_reg         <= action_next;
        end
    end

    `RBTS_ASSERT_NOW(a_out_tracks_state, clk, rst_n, out_valid_reg, torque_fine_reg == torque_accum_reg)
    `RBTS_ASSERT_NEXT(a_sensor_lost, clk, rst_n, sample_acc && !sample.sensor_valid, out_valid_reg && first_sample_reg && (action_reg == rbts_pkg::ACT_SENSOR_LOST))
    `RBTS_ASSERT_NEXT(a_first_silent, clk, rst_n, sample_acc && sample.sensor_valid && first_sample_reg, !out_valid_reg && !first_sample_reg)
    `RBTS_ASSERT_NOW(a_cut_zero, clk, rst_n, out_valid_reg && ((action_reg == rbts_pkg::ACT_ANGLE_CUT) || (action_reg == rbts_pkg::ACT_TORQUE_CUT) || (action_reg == rbts_pkg::ACT_SENSOR_LOST)), (torque_fine_reg == '0) && (torque_command_reg == '0))

endmodule

// ----- bench/rate_bounded_torque_stepper_tb.sv -----
// Self-checking bench for rate_bounded_torque_stepper: random sample requests with
// idles and stalls, a built-in torque predictor and an in-order result scoreboard.
// Depends on rbts_pkg, rbts_if and the block itself.
`timescale 1ns / 100ps

module rate_bounded_torque_stepper_tb;

    localparam int ANGLE_BITS  = 16;
    localparam int TFRAC       = 8;
    localparam int PHASES      = 12;
    localparam int PHASE_TICKS = 125;
    localparam int PRESS_PHASE = 5;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 6;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        bit                                     sens;
        bit                                     tgt_set;
        logic signed [ANGLE_BITS-1:0]           tgt;
        logic signed [ANGLE_BITS-1:0]           meas;
        logic signed [rbts_pkg::RATE_W-1:0]     rate;
    } tick_t;

    typedef struct {
        logic signed [rbts_pkg::TORQUE_W-1:0]   fine;
        logic signed [rbts_pkg::CMD_W-1:0]      cmd;
        rbts_pkg::action_t                      act;
    } torque_out_t;

    logic clk;
    logic rst_n;

    rbts_sample_if #(.ANGLE_BITS(ANGLE_BITS)) sample_ch ();
    rbts_result_if result_ch ();
    rbts_cfg_if    cfg_ch ();

    rate_bounded_torque_stepper #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TORQUE_FRAC_BITS(TFRAC)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .sample(sample_ch),
        .result(result_ch)
    );

    tick_t       tick_q[$];
    torque_out_t torque_expect_q[$];

    // predictor state and register copy
    longint trq = 0;
    bit     first_pending = 1'b1;
    longint cur_angle_limit = rbts_pkg::RST_ANGLE_LIMIT;
    longint cur_torque_limit = rbts_pkg::RST_TORQUE_LIMIT;
    longint cur_tolerance = rbts_pkg::RST_ANGLE_TOLERANCE;
    longint cur_full_res = rbts_pkg::RST_FULL_RATE_RES;
    longint cur_min_rate = rbts_pkg::RST_MIN_RATE;
    longint cur_max_rate = rbts_pkg::RST_MAX_RATE;
    longint cur_step = rbts_pkg::RST_TORQUE_STEP;

    // settings used to shape stimulus
    int plan_angle_limit = rbts_pkg::RST_ANGLE_LIMIT;
    int plan_torque_limit = rbts_pkg::RST_TORQUE_LIMIT;
    int plan_tolerance = rbts_pkg::RST_ANGLE_TOLERANCE;
    int plan_full_res = rbts_pkg::RST_FULL_RATE_RES;
    int plan_min_rate = rbts_pkg::RST_MIN_RATE;
    int plan_max_rate = rbts_pkg::RST_MAX_RATE;
    int plan_step = rbts_pkg::RST_TORQUE_STEP;

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int tx_gap = 0;
    bit tx_calm = 1'b0;
    int rx_wait = 0;
    bit rx_calm = 1'b0;
    int hold_asked = 0;
    int hold_done = 0;
    int stall_cycles = 0;

    int errors = 0;
    int n_ticks = 0;
    int n_checked = 0;
    int n_writes = 0;
    int act_seen[7];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void apply_reg(input logic [rbts_pkg::CFG_ADDR_W-1:0] idx,
                                      input logic [rbts_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            rbts_pkg::CFG_ANGLE_LIMIT:     cur_angle_limit = val[rbts_pkg::LIM_W-1:0];
            rbts_pkg::CFG_TORQUE_LIMIT:    cur_torque_limit = val[rbts_pkg::TLIM_W-1:0];
            rbts_pkg::CFG_ANGLE_TOLERANCE: cur_tolerance = val[rbts_pkg::LIM_W-1:0];
            rbts_pkg::CFG_FULL_RATE_RES:   cur_full_res = val[rbts_pkg::LIM_W-1:0];
            rbts_pkg::CFG_MIN_RATE:        cur_min_rate = val[rbts_pkg::LIM_W-1:0];
            rbts_pkg::CFG_MAX_RATE:        cur_max_rate = val[rbts_pkg::LIM_W-1:0];
            rbts_pkg::CFG_TORQUE_STEP:     cur_step = val[rbts_pkg::STEP_W-1:0];
            default:                       ;
        endcase
    endfunction

    function automatic bit rate_exceeds(input longint v, input longint r);
        longint slope;
        slope = cur_full_res - cur_tolerance;
        if (r <= -cur_full_res)
            return v > -cur_min_rate;
        if (v > cur_max_rate)
            return 1'b1;
        if (slope <= 0)
            slope = 1;
        return v * slope > cur_min_rate * (r + cur_tolerance);
    endfunction

    function automatic bit advance_torque(input tick_t t, output torque_out_t o);
        longint ms;
        longint resid;
        longint cut;
        longint lim;
        longint nxt;
        longint cmd;
        rbts_pkg::action_t act;
        act = rbts_pkg::ACT_HELD;
        if (!t.sens)
        begin
            trq = 0;
            first_pending = 1'b1;
            act = rbts_pkg::ACT_SENSOR_LOST;
        end
        else if (first_pending)
        begin
            first_pending = 1'b0;
            return 1'b0;
        end
        else if (!t.tgt_set)
            act = rbts_pkg::ACT_NO_TARGET;
        else
        begin
            ms = t.meas;
            resid = longint'(t.tgt) - ms;
            cut = (cur_torque_limit + 1) << TFRAC;
            if ((ms < 0 ? -ms : ms) > cur_angle_limit)
            begin
                trq = 0;
                act = rbts_pkg::ACT_ANGLE_CUT;
            end
            else if ((trq < 0 ? -trq : trq) > cut)
            begin
                trq = 0;
                act = rbts_pkg::ACT_TORQUE_CUT;
            end
            else
            begin
                lim = cur_torque_limit << TFRAC;
                if (lim > longint'(rbts_pkg::FINE_MAX))
                    lim = rbts_pkg::FINE_MAX;
                nxt = trq;
                if (rate_exceeds(t.rate, resid))
                begin
                    nxt = nxt - cur_step;
                    act = rbts_pkg::ACT_DOWN;
                end
                else if (rate_exceeds(-longint'(t.rate), -resid))
                begin
                    nxt = nxt + cur_step;
                    act = rbts_pkg::ACT_UP;
                end
                if (nxt < -lim)
                    nxt = -lim;
                if (nxt > lim)
                    nxt = lim;
                trq = nxt;
            end
        end
        cmd = trq < 0 ? -((-trq) >>> TFRAC) : trq >>> TFRAC;
        if (cmd > longint'(rbts_pkg::CMD_POS_MAX))
            cmd = rbts_pkg::CMD_POS_MAX;
        if (cmd < -longint'(rbts_pkg::CMD_NEG_MAX))
            cmd = -longint'(rbts_pkg::CMD_NEG_MAX);
        o.fine = trq[rbts_pkg::TORQUE_W-1:0];
        o.cmd = cmd[rbts_pkg::CMD_W-1:0];
        o.act = act;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] clip16(input longint x);
        if (x > 32767)
            return 16'sd32767;
        if (x < -32768)
            return -16'sd32768;
        return x[15:0];
    endfunction

    function automatic int rand_in(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic tick_t mk_tick(input bit s, input bit ts, input int tg,
                                      input int ms, input int rt);
        tick_t t;
        t.sens = s;
        t.tgt_set = ts;
        t.tgt = clip16(tg);
        t.meas = clip16(ms);
        t.rate = clip16(rt);
        return t;
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int span;
        t.sens = $urandom_range(0, 99) >= 4;
        t.tgt_set = $urandom_range(0, 99) >= 8;
        if ($urandom_range(0, 99) < 12)
        begin
            t.tgt = 16'($urandom);
            t.meas = 16'($urandom);
            t.rate = 16'($urandom);
        end
        else
        begin
            span = plan_angle_limit + plan_angle_limit / 16 + 4;
            t.meas = clip16(rand_in(span));
            span = 2 * plan_full_res + plan_tolerance + 4;
            t.tgt = clip16(longint'(t.meas) + rand_in(span));
            span = plan_max_rate + plan_max_rate / 4 + plan_min_rate + 4;
            t.rate = clip16(rand_in(span));
        end
        return t;
    endfunction

    task automatic pick_settings(input int p);
        bit wide;
        wide = $urandom_range(0, 3) == 0;
        if (p == 1)
        begin
            plan_angle_limit = 32767; plan_torque_limit = 255; plan_tolerance = 32767;
            plan_full_res = 32767; plan_min_rate = 32767; plan_max_rate = 32767;
            plan_step = 65535;
        end
        else if (p == 2)
        begin
            plan_angle_limit = 0; plan_torque_limit = 0; plan_tolerance = 1;
            plan_full_res = 1; plan_min_rate = 0; plan_max_rate = 1; plan_step = 1;
        end
        else
        begin
            plan_angle_limit = wide ? $urandom_range(0, 32767) : $urandom_range(200, 6000);
            plan_torque_limit = $urandom_range(0, 255);
            plan_tolerance = wide ? $urandom_range(1, 32767) : $urandom_range(1, 200);
            plan_full_res = wide ? $urandom_range(1, 32767) : $urandom_range(1, 1200);
            plan_min_rate = wide ? $urandom_range(0, 32767) : $urandom_range(0, 600);
            plan_max_rate = wide ? $urandom_range(1, 32767) : $urandom_range(1, 4000);
            plan_step = wide ? $urandom_range(1, 65535) : $urandom_range(1, 3000);
            // tolerance at or above full-rate residual: flat slope
            if (p == 3)
            begin
                plan_tolerance = $urandom_range(100, 2000);
                plan_full_res = $urandom_range(1, plan_tolerance);
            end
        end
    endtask

    task automatic write_reg(input logic [rbts_pkg::CFG_ADDR_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= 16'(val);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (tick_q.size() != 0 || sample_ch.valid || torque_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    initial
    begin : main
        int p;
        int k;
        sample_ch.valid = 1'b0;
        sample_ch.sensor_valid = 1'b0;
        sample_ch.target_valid = 1'b0;
        sample_ch.target_angle = '0;
        sample_ch.measured_angle = '0;
        sample_ch.angular_rate = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = rbts_pkg::CFG_ANGLE_LIMIT;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                pick_settings(p);
                write_reg(rbts_pkg::CFG_ANGLE_LIMIT, plan_angle_limit);
                write_reg(rbts_pkg::CFG_TORQUE_LIMIT, plan_torque_limit);
                write_reg(rbts_pkg::CFG_ANGLE_TOLERANCE, plan_tolerance);
                write_reg(rbts_pkg::CFG_FULL_RATE_RES, plan_full_res);
                write_reg(rbts_pkg::CFG_MIN_RATE, plan_min_rate);
                write_reg(rbts_pkg::CFG_MAX_RATE, plan_max_rate);
                write_reg(rbts_pkg::CFG_TORQUE_STEP, plan_step);
                @(negedge clk);
                cfg_ch.valid <= 1'b0;
            end
            if (p == 0)
            begin
                // first sample swallowed, loss, re-sync
                tick_q.push_back(mk_tick(1, 1, 0, 0, 0));
                tick_q.push_back(mk_tick(0, 1, 0, 0, 0));
                tick_q.push_back(mk_tick(1, 0, -1, -1, -1));
                tick_q.push_back(mk_tick(1, 0, 32767, -32768, 32767));
                tick_q.push_back(mk_tick(1, 1, 0, 4501, 0));
                tick_q.push_back(mk_tick(1, 1, 0, -4501, 0));
                tick_q.push_back(mk_tick(1, 1, 4500, 4500, 0));
                tick_q.push_back(mk_tick(1, 1, 0, 0, 0));
                tick_q.push_back(mk_tick(1, 1, 0, 0, 2001));
                tick_q.push_back(mk_tick(1, 1, 0, 0, -2001));
                tick_q.push_back(mk_tick(1, 1, -100, 0, -49));
                tick_q.push_back(mk_tick(1, 1, -100, 0, -50));
                tick_q.push_back(mk_tick(1, 1, 50, 0, 30));
                tick_q.push_back(mk_tick(1, 1, 50, 0, 40));
                tick_q.push_back(mk_tick(1, 1, -50, 0, -40));
                tick_q.push_back(mk_tick(1, 1, 32767, -32768, 0));
                tick_q.push_back(mk_tick(1, 1, -32768, 32767, 0));
                tick_q.push_back(mk_tick(1, 1, 32767, 0, 32767));
                tick_q.push_back(mk_tick(1, 1, -32768, 0, -32768));
                tick_q.push_back(mk_tick(1, 1, 0, 0, -32768));
                tick_q.push_back(mk_tick(0, 0, -32768, 32767, -32768));
                tick_q.push_back(mk_tick(1, 1, 0, 0, 0));
            end
            if (p == PRESS_PHASE)
                hold_asked++;
            for (k = 0; k < PHASE_TICKS; k++)
                tick_q.push_back(random_tick());
            // drive torque to the top so the next, tighter setting trips the torque cut
            if (p == 1)
            begin
                tick_q.push_back(mk_tick(1, 1, 1000, 0, -32768));
                tick_q.push_back(mk_tick(1, 1, 1000, 0, -32768));
                tick_q.push_back(mk_tick(1, 1, 1000, 0, -32768));
            end
            if (p == 2)
                tick_q.push_front(mk_tick(1, 1, 0, 0, 0));
        end

        wait_idle();
        $display("covered %0d sample requests, %0d checked results, %0d register writes",
                 n_ticks, n_checked, n_writes);
        $display("held/down/up/angle cut/torque cut/lost/no target: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 act_seen[rbts_pkg::ACT_HELD], act_seen[rbts_pkg::ACT_DOWN],
                 act_seen[rbts_pkg::ACT_UP], act_seen[rbts_pkg::ACT_ANGLE_CUT],
                 act_seen[rbts_pkg::ACT_TORQUE_CUT], act_seen[rbts_pkg::ACT_SENSOR_LOST],
                 act_seen[rbts_pkg::ACT_NO_TARGET]);
        if (errors == 0)
            $display("rate_bounded_torque_stepper_tb: done, clean");
        else
            $display("rate_bounded_torque_stepper_tb: done, errors");
        $finish;
    end

    always @(negedge clk)
    begin : drive
        tick_t nxt;
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || in_taken)
        begin
            if (tx_gap != 0)
            begin
                sample_ch.valid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (tick_q.size() != 0)
            begin
                nxt = tick_q.pop_front();
                sample_ch.valid <= 1'b1;
                sample_ch.sensor_valid <= nxt.sens;
                sample_ch.target_valid <= nxt.tgt_set;
                sample_ch.target_angle <= nxt.tgt;
                sample_ch.measured_angle <= nxt.meas;
                sample_ch.angular_rate <= nxt.rate;
                if ($urandom_range(0, 19) == 0)
                    tx_calm <= !tx_calm;
                tx_gap <= tx_calm ? 0 : $urandom_range(0, 11);
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : receive
        int stall;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_asked != hold_done)
        begin
            hold_done <= hold_done + 1;
            rx_wait <= LONG_HOLD;
            result_ch.ready <= 1'b0;
        end
        else if (rx_wait > 0)
        begin
            rx_wait <= rx_wait - 1;
            result_ch.ready <= 1'b0;
        end
        else if (out_taken)
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm <= !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall == 0)
                result_ch.ready <= 1'b1;
            else
            begin
                result_ch.ready <= 1'b0;
                rx_wait <= stall - 1;
            end
        end
        else
            result_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        tick_t       got;
        torque_out_t want;
        in_taken <= sample_ch.valid && sample_ch.ready;
        out_taken <= result_ch.valid && result_ch.ready;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                apply_reg(cfg_ch.addr, cfg_ch.data);
                n_writes++;
            end
            // result side first: a result never belongs to a request taken this cycle
            if (result_ch.valid && result_ch.ready)
            begin
                if (torque_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result fine %0d cmd %0d action %0d", $time,
                             result_ch.torque_fine, result_ch.torque_command,
                             result_ch.action);
                    errors++;
                end
                else
                begin
                    want = torque_expect_q.pop_front();
                    n_checked++;
                    act_seen[want.act]++;
                    if (result_ch.torque_fine !== want.fine)
                    begin
                        $display("%0t: torque_fine expected %0d got %0d", $time,
                                 want.fine, result_ch.torque_fine);
                        errors++;
                    end
                    if (result_ch.torque_command !== want.cmd)
                    begin
                        $display("%0t: torque_command expected %0d got %0d", $time,
                                 want.cmd, result_ch.torque_command);
                        errors++;
                    end
                    if (result_ch.action !== want.act)
                    begin
                        $display("%0t: action expected %0d got %0d", $time,
                                 want.act, result_ch.action);
                        errors++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                got.sens = sample_ch.sensor_valid;
                got.tgt_set = sample_ch.target_valid;
                got.tgt = sample_ch.target_angle;
                got.meas = sample_ch.measured_angle;
                got.rate = sample_ch.angular_rate;
                n_ticks++;
                if (advance_torque(got, want))
                    torque_expect_q.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, stall_cycles);
                $display("rate_bounded_torque_stepper_tb: done, errors");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
